[rtl/ldcm_pkg.sv]
package ldcm_pkg;

  typedef enum logic [2:0] {
    REG_FOCAL_X       = 3'd0,
    REG_FOCAL_Y       = 3'd1,
    REG_PRINCIPAL     = 3'd2,
    REG_RADIAL_K1     = 3'd3,
    REG_RADIAL_K2     = 3'd4,
    REG_RADIAL_K3     = 3'd5,
    REG_TANGENTIAL_P1 = 3'd6,
    REG_TANGENTIAL_P2 = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [19:0]        fx;
    logic [19:0]        fy;
    logic [15:0]        cx;
    logic [15:0]        cy;
    logic signed [23:0] k1;
    logic signed [23:0] k2;
    logic signed [23:0] k3;
    logic signed [23:0] p1;
    logic signed [23:0] p2;
  } lens_cfg_t;

  localparam logic [19:0] FOCAL_RESET     = 20'd134400;
  localparam logic [31:0] PRINCIPAL_RESET = 32'd1340095456;

  localparam logic signed [27:0] Q24_MAX = 28'sh7FFFFFF;
  localparam logic signed [27:0] Q24_MIN = 28'sh8000000;
  localparam logic signed [63:0] Q24_ONE = 64'sd16777216;

  localparam int QBITS    = 28;
  localparam int NORM_LAT = QBITS + 2;
  localparam int WARP_LAT = 8;
  localparam int DEN_LAT  = 3;
  localparam int LAT      = NORM_LAT + WARP_LAT + DEN_LAT;

  function automatic logic signed [27:0] sat_q24(input logic signed [63:0] v);
    logic signed [27:0] r;
    if (v > 64'(Q24_MAX)) r = Q24_MAX;
    else if (v < 64'(Q24_MIN)) r = Q24_MIN;
    else r = v[27:0];
    return r;
  endfunction

endpackage

[rtl/ldcm_cfg.sv]
module ldcm_cfg (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [4:0]               cfg_paddr,
  input  logic [31:0]              cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready,
  output ldcm_pkg::lens_cfg_t      cfg
);

  logic [19:0] fx_r, fy_r;
  logic [31:0] pp_r;
  logic [23:0] k1_r, k2_r, k3_r, p1_r, p2_r;
  ldcm_pkg::reg_idx_t idx;
  logic wr;

  assign idx        = ldcm_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_r <= ldcm_pkg::FOCAL_RESET;
      fy_r <= ldcm_pkg::FOCAL_RESET;
      pp_r <= ldcm_pkg::PRINCIPAL_RESET;
      k1_r <= '0;
      k2_r <= '0;
      k3_r <= '0;
      p1_r <= '0;
      p2_r <= '0;
    end else if (wr) begin
      case (idx)
        ldcm_pkg::REG_FOCAL_X:       fx_r <= cfg_pwdata[19:0];
        ldcm_pkg::REG_FOCAL_Y:       fy_r <= cfg_pwdata[19:0];
        ldcm_pkg::REG_PRINCIPAL:     pp_r <= cfg_pwdata;
        ldcm_pkg::REG_RADIAL_K1:     k1_r <= cfg_pwdata[23:0];
        ldcm_pkg::REG_RADIAL_K2:     k2_r <= cfg_pwdata[23:0];
        ldcm_pkg::REG_RADIAL_K3:     k3_r <= cfg_pwdata[23:0];
        ldcm_pkg::REG_TANGENTIAL_P1: p1_r <= cfg_pwdata[23:0];
        ldcm_pkg::REG_TANGENTIAL_P2: p2_r <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ldcm_pkg::REG_FOCAL_X:       cfg_prdata = {12'd0, fx_r};
      ldcm_pkg::REG_FOCAL_Y:       cfg_prdata = {12'd0, fy_r};
      ldcm_pkg::REG_PRINCIPAL:     cfg_prdata = pp_r;
      ldcm_pkg::REG_RADIAL_K1:     cfg_prdata = {8'd0, k1_r};
      ldcm_pkg::REG_RADIAL_K2:     cfg_prdata = {8'd0, k2_r};
      ldcm_pkg::REG_RADIAL_K3:     cfg_prdata = {8'd0, k3_r};
      ldcm_pkg::REG_TANGENTIAL_P1: cfg_prdata = {8'd0, p1_r};
      ldcm_pkg::REG_TANGENTIAL_P2: cfg_prdata = {8'd0, p2_r};
      default:                     cfg_prdata = '0;
    endcase
  end

  // zero focal length is taken as 1/256 pixel
  always_comb begin
    cfg.fx = (fx_r == '0) ? 20'd1 : fx_r;
    cfg.fy = (fy_r == '0) ? 20'd1 : fy_r;
    cfg.cx = pp_r[31:16];
    cfg.cy = pp_r[15:0];
    cfg.k1 = $signed(k1_r);
    cfg.k2 = $signed(k2_r);
    cfg.k3 = $signed(k3_r);
    cfg.p1 = $signed(p1_r);
    cfg.p2 = $signed(p2_r);
  end

endmodule

[rtl/ldcm_norm.sv]
// (pix - centre) / focal in Q4.24, one quotient bit per stage
module ldcm_norm #(
  parameter int COORD_BITS = 10
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [COORD_BITS-1:0]  pix,
  input  logic [15:0]            center,
  input  logic [19:0]            focal,
  output logic signed [27:0]     q
);

  localparam int DW = ((COORD_BITS + 6 > 16) ? COORD_BITS + 6 : 16) + 1;
  localparam int MW = DW - 1;
  localparam int CW = (MW > 22) ? MW : 22;
  localparam int NQ = ldcm_pkg::QBITS;

  logic signed [DW-1:0] d;
  logic signed [DW-1:0] dabs;
  logic [MW-1:0]        mag;
  logic                 ovf;

  logic [19:0]   rem_r [0:NQ];
  logic [NQ-1:0] quo_r [0:NQ];
  logic [1:0]    lb_r  [0:NQ];
  logic          neg_r [0:NQ];
  logic          ovf_r [0:NQ];
  logic signed [27:0] q_r, q_nxt;

  always_comb begin
    d    = DW'($signed({1'b0, pix, 6'b0})) - DW'($signed({1'b0, center}));
    dabs = (d < 0) ? -d : d;
    mag  = dabs[MW-1:0];
    // quotient of 2^28 or more saturates either way
    ovf  = CW'(mag) >= CW'({focal, 2'b00});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= 20'(mag >> 2);
      quo_r[0] <= '0;
      lb_r[0]  <= mag[1:0];
      neg_r[0] <= d < 0;
      ovf_r[0] <= ovf;
    end
  end

  for (genvar gi = 0; gi < NQ; gi++) begin : g_div
    logic        nb;
    logic [20:0] trial;
    logic        ge;
    always_comb begin
      nb    = (gi == 0) ? lb_r[gi][1] : ((gi == 1) ? lb_r[gi][0] : 1'b0);
      trial = {rem_r[gi], nb};
      ge    = trial >= {1'b0, focal};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[gi+1] <= ge ? 20'(trial - {1'b0, focal}) : trial[19:0];
        quo_r[gi+1] <= {quo_r[gi][NQ-2:0], ge};
        lb_r[gi+1]  <= lb_r[gi];
        neg_r[gi+1] <= neg_r[gi];
        ovf_r[gi+1] <= ovf_r[gi];
      end
    end
  end

  always_comb begin
    if (!neg_r[NQ]) begin
      if (ovf_r[NQ] || quo_r[NQ][NQ-1]) q_nxt = ldcm_pkg::Q24_MAX;
      else q_nxt = $signed(quo_r[NQ]);
    end else begin
      if (ovf_r[NQ] || (quo_r[NQ] > {1'b1, {(NQ-1){1'b0}}})) q_nxt = ldcm_pkg::Q24_MIN;
      else q_nxt = -$signed(quo_r[NQ]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

[rtl/ldcm_warp.sv]
module ldcm_warp (
  input  logic                clk,
  input  logic                en,
  input  logic signed [27:0]  x,
  input  logic signed [27:0]  y,
  input  ldcm_pkg::lens_cfg_t cfg,
  output logic signed [27:0]  xd,
  output logic signed [27:0]  yd
);

  logic signed [27:0] x_r [1:6];
  logic signed [27:0] y_r [1:6];
  logic signed [27:0] xsq_r, ysq_r, xy_r;
  logic signed [27:0] r2_r [2:4];
  logic signed [27:0] tx_r, ty_r, xy2_r;
  logic signed [27:0] r4_r, r6_r;
  logic signed [33:0] t1_r [3:5];
  logic signed [33:0] t2_r [4:5];
  logic signed [33:0] t3_r;
  logic signed [33:0] gxa_r [3:7];
  logic signed [33:0] gxb_r [3:7];
  logic signed [33:0] gya_r [3:7];
  logic signed [33:0] gyb_r [3:7];
  logic signed [27:0] rad_r;
  logic signed [33:0] xr_r, yr_r;
  logic signed [27:0] xd_r, yd_r;

  logic signed [55:0] pxx, pyy, pxy, pr4, pr6, pxr, pyr;
  logic signed [51:0] pk1, pk2, pk3, pxa, pxb, pya, pyb;
  logic signed [27:0] r2s;

  always_comb begin
    pxx = x * x;
    pyy = y * y;
    pxy = x * y;
    r2s = ldcm_pkg::sat_q24(64'(xsq_r) + 64'(ysq_r));
    pr4 = r2_r[2] * r2_r[2];
    pk1 = cfg.k1 * r2_r[2];
    pxa = cfg.p2 * xy2_r;
    pxb = cfg.p1 * tx_r;
    pya = cfg.p2 * ty_r;
    pyb = cfg.p1 * xy2_r;
    pr6 = r4_r * r2_r[3];
    pk2 = cfg.k2 * r4_r;
    pk3 = cfg.k3 * r6_r;
    pxr = x_r[6] * rad_r;
    pyr = y_r[6] * rad_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[1] <= x;
      y_r[1] <= y;
      for (int i = 2; i <= 6; i++) begin
        x_r[i] <= x_r[i-1];
        y_r[i] <= y_r[i-1];
      end
      // squares and cross term
      xsq_r <= ldcm_pkg::sat_q24(64'(pxx >>> 24));
      ysq_r <= ldcm_pkg::sat_q24(64'(pyy >>> 24));
      xy_r  <= ldcm_pkg::sat_q24(64'(pxy >>> 24));
      // r2 and tangential bases
      r2_r[2] <= r2s;
      tx_r    <= ldcm_pkg::sat_q24(64'(r2s) + (64'(xsq_r) <<< 1));
      ty_r    <= ldcm_pkg::sat_q24(64'(r2s) + (64'(ysq_r) <<< 1));
      xy2_r   <= xy_r;
      r2_r[3] <= r2_r[2];
      r2_r[4] <= r2_r[3];
      // r4, k1 term, tangential products
      r4_r     <= ldcm_pkg::sat_q24(64'(pr4 >>> 24));
      t1_r[3]  <= 34'(pk1 >>> 20);
      gxa_r[3] <= 34'(pxa >>> 19);
      gxb_r[3] <= 34'(pxb >>> 20);
      gya_r[3] <= 34'(pya >>> 20);
      gyb_r[3] <= 34'(pyb >>> 19);
      for (int i = 4; i <= 7; i++) begin
        gxa_r[i] <= gxa_r[i-1];
        gxb_r[i] <= gxb_r[i-1];
        gya_r[i] <= gya_r[i-1];
        gyb_r[i] <= gyb_r[i-1];
      end
      // r6 and k2 term
      r6_r    <= ldcm_pkg::sat_q24(64'(pr6 >>> 24));
      t2_r[4] <= 34'(pk2 >>> 20);
      t1_r[4] <= t1_r[3];
      // k3 term
      t3_r    <= 34'(pk3 >>> 20);
      t2_r[5] <= t2_r[4];
      t1_r[5] <= t1_r[4];
      // radial factor
      rad_r <= ldcm_pkg::sat_q24(ldcm_pkg::Q24_ONE + 64'(t1_r[5]) + 64'(t2_r[5])
                                 + 64'(t3_r));
      xr_r <= 34'(pxr >>> 24);
      yr_r <= 34'(pyr >>> 24);
      xd_r <= ldcm_pkg::sat_q24(64'(xr_r) + 64'(gxa_r[7]) + 64'(gxb_r[7]));
      yd_r <= ldcm_pkg::sat_q24(64'(yr_r) + 64'(gya_r[7]) + 64'(gyb_r[7]));
    end
  end

  assign xd = xd_r;
  assign yd = yd_r;

endmodule

[rtl/ldcm_denorm.sv]
// v*f + centre + 1/2 in Q.32, truncated toward zero, low 16 bits
module ldcm_denorm (
  input  logic               clk,
  input  logic               en,
  input  logic signed [27:0] v,
  input  logic [19:0]        focal,
  input  logic [15:0]        center,
  output logic [15:0]        coord
);

  logic signed [48:0] prod_r;
  logic signed [50:0] t_r;
  logic signed [50:0] adj;
  logic [15:0]        coord_r;

  always_comb begin
    adj = t_r + ((t_r < 0) ? 51'sd4294967295 : 51'sd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= v * $signed({1'b0, focal});
      t_r     <= 51'(prod_r) + $signed({9'd0, center, 26'd0}) + 51'sd2147483648;
      coord_r <= adj[47:32];
    end
  end

  assign coord = coord_r;

endmodule

[rtl/lens_distortion_coordinate_map_core.sv]
// Pipeline from request accept to result valid: 30 divider stages,
// 8 distortion stages, 3 back-scaling stages.
// Throughput: one request per cycle; the whole pipeline holds while a result
// waits at the output, and the normalising division sets the depth.
// Reset: synchronous active-low; clears valid bits and reloads registers.
module lens_distortion_coordinate_map_core #(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_pixel_col,
  input  logic [COORD_BITS-1:0] in_pixel_row,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           out_source_col,
  output logic [15:0]           out_source_row,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [4:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int LAT = ldcm_pkg::LAT;

  ldcm_pkg::lens_cfg_t cfg;
  logic adv;
  logic [LAT-1:0] vld_r;
  logic signed [27:0] xn, yn, xd, yd;

  ldcm_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready, .cfg
  );

  assign adv       = !vld_r[LAT-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[LAT-2:0], in_valid};
  end

  ldcm_norm #(.COORD_BITS(COORD_BITS)) u_norm_x (
    .clk, .en(adv), .pix(in_pixel_col), .center(cfg.cx), .focal(cfg.fx), .q(xn)
  );

  ldcm_norm #(.COORD_BITS(COORD_BITS)) u_norm_y (
    .clk, .en(adv), .pix(in_pixel_row), .center(cfg.cy), .focal(cfg.fy), .q(yn)
  );

  ldcm_warp u_warp (
    .clk, .en(adv), .x(xn), .y(yn), .cfg, .xd, .yd
  );

  ldcm_denorm u_den_x (
    .clk, .en(adv), .v(xd), .focal(cfg.fx), .center(cfg.cx), .coord(out_source_col)
  );

  ldcm_denorm u_den_y (
    .clk, .en(adv), .v(yd), .focal(cfg.fy), .center(cfg.cy), .coord(out_source_row)
  );

`ifndef SYNTHESIS
  logic [6:0] occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) occ_r <= '0;
    else occ_r <= occ_r + 7'(in_valid && in_ready) - 7'(out_valid && out_ready);
  end

  a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
    32'(occ_r) == $countones(vld_r))
    else $error("in-flight count disagrees with pipeline valid bits");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted request missing from first stage");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> vld_r == $past(vld_r))
    else $error("pipeline moved while stalled");
`endif

endmodule
